>>> hdl/aht_pkg.sv
// Shared types, constants and the blend arithmetic of the access heat tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package aht_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HEAT_W    = 64;
    localparam int TIME_W    = 32;
    localparam int WEIGHT_W  = 9;
    localparam int ACT_W     = 2;
    localparam int IN_IDX_W  = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL   = WEIGHT_W'(256);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = WEIGHT_W'(128);
    localparam logic [TIME_W-1:0]   PERIOD_RESET  = TIME_W'(60);

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLR = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_WEIGHT = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic [HEAT_W-1:0] count;
        logic [TIME_W-1:0] start;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic             set_valid;   // 0: entry goes back to all zero
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    // heat*(256-w)/256 + count*w/256, products wrap at 64 bits
    function automatic logic [HEAT_W-1:0] blend(input logic [HEAT_W-1:0]   h,
                                                input logic [HEAT_W-1:0]   c,
                                                input logic [WEIGHT_W-1:0] w);
        logic [HEAT_W-1:0] ph;
        logic [HEAT_W-1:0] pc;
        ph = h * HEAT_W'(WEIGHT_FULL - w);
        pc = c * HEAT_W'(w);
        return (ph >> 8) + (pc >> 8);
    endfunction

endpackage

`default_nettype wire

>>> hdl/aht_entry_mem.sv
// Heat entry memory: one synchronous RAM of t_entry words plus per-entry valid bits.
// An entry whose valid bit is clear reads as all zero. Depends on aht_pkg.
`default_nettype none

module aht_entry_mem
    import aht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_data,
    input  wire t_mem_wr          i_wr
);

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= i_wr.set_valid;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> hdl/aht_period_div.sv
// Restoring divider, one quotient bit per cycle, for the elapsed-period count.
// Depends on aht_pkg for widths.
`default_nettype none

module aht_period_div
    import aht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [TIME_W-1:0] i_dividend,
    input  wire logic [TIME_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [TIME_W-1:0]      o_quotient,
    output logic [TIME_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(TIME_W);

    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TIME_W:0]   sh;
    logic              ge;

    assign sh = {r_rem, r_quo[TIME_W-1]};
    assign ge = (sh >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? TIME_W'(sh - {1'b0, i_divisor}) : TIME_W'(sh);
            r_quo <= {r_quo[TIME_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> hdl/access_heat_tracker_top.sv
// Access heat tracker top: request FSM, decay loop, APB registers, result register.
// Depends on aht_pkg, aht_entry_mem and aht_period_div.
//
// One request is worked at a time. A request goes through accept, memory read and write
// back when no whole period has elapsed for its entry, with one decay step between read
// and write back when exactly one has. When two or more periods have elapsed, the period
// divider runs first, then the decay loop handles one elapsed period per cycle through
// the shared blend multiplier, stopping early once the heat settles. A get waits in its
// write-back state while the result register still holds an untaken result; a new
// request is accepted while a finished result waits. Entries read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module access_heat_tracker_top
    import aht_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [IN_IDX_W-1:0] i_entry_index,
    input  wire logic [TIME_W-1:0]   i_time_now,
    input  wire logic [HEAT_W-1:0]   i_access_count,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [HEAT_W-1:0]        o_heat_out,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_DIV    = 5'b00100,
        S_DECAY  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // configuration
    logic [WEIGHT_W-1:0] r_weight;
    logic [TIME_W-1:0]   r_period;
    logic [WEIGHT_W-1:0] w_eff;
    logic [TIME_W-1:0]   p_eff;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
            r_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WEIGHT: r_weight <= pwdata[WEIGHT_W-1:0];
                REG_PERIOD: r_period <= pwdata[TIME_W-1:0];
                default:    r_weight <= r_weight;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WEIGHT: prdata = APB_DW'(r_weight);
            REG_PERIOD: prdata = APB_DW'(r_period);
            default:    prdata = '0;
        endcase
    end

    assign w_eff = (r_weight > WEIGHT_FULL) ? WEIGHT_FULL : r_weight;
    assign p_eff = (r_period == '0) ? TIME_W'(1) : r_period;

    // request state
    t_state            r_state, n_state;
    logic [ACT_W-1:0]  r_act;
    logic [IDX_W-1:0]  r_idx;
    logic              r_inr, n_inr;
    logic [TIME_W-1:0] r_now;
    logic [HEAT_W-1:0] r_cnt;
    logic [HEAT_W-1:0] r_heat, n_heat;
    logic [HEAT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_n, n_n;
    logic              r_out_valid, n_out_valid;
    logic [HEAT_W-1:0] r_heat_out, n_heat_out;

    logic              accept;
    t_entry            rd;
    t_mem_wr           wr;
    logic [HEAT_W-1:0] blend_val;
    logic              settled;
    logic              out_free;
    logic [TIME_W-1:0] diff_m1;
    logic [TIME_W-1:0] over_one;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [TIME_W-1:0] div_quo;
    logic [TIME_W-1:0] div_rem;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign blend_val  = blend(r_heat, r_count, w_eff);
    assign settled    = (r_count == '0) && (blend_val == r_heat);
    assign diff_m1    = r_now - rd.start - TIME_W'(1);
    assign over_one   = diff_m1 - p_eff;

    aht_entry_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (IDX_W'(i_entry_index)),
        .o_rd_data (rd),
        .i_wr      (wr)
    );

    aht_period_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (diff_m1),
        .i_divisor   (p_eff),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_inr       = r_inr;
        n_heat      = r_heat;
        n_count     = r_count;
        n_start     = r_start;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_out_ready;
        n_heat_out  = r_heat_out;
        div_start   = 1'b0;
        wr          = '0;
        wr.addr     = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                    n_inr   = (32'(i_entry_index) < ENTRIES);
                end
            end
            S_READ: begin
                n_heat  = rd.heat;
                n_count = rd.count;
                n_start = rd.start;
                n_state = S_FINISH;
                if (!r_inr) begin
                    n_heat  = '0;
                    n_count = '0;
                    if (r_act != ACT_GET) begin
                        n_state = S_IDLE;
                    end
                end else if (r_act == ACT_CLR) begin
                    wr.en        = 1'b1;
                    wr.set_valid = 1'b0;
                    n_state      = S_IDLE;
                end else if (r_act != ACT_ADD && r_act != ACT_GET) begin
                    n_state = S_IDLE;
                end else if (rd.start > r_now) begin
                    // time went backwards: entry restarts from zero
                    n_heat  = '0;
                    n_count = '0;
                    n_start = '0;
                end else if (rd.start == '0 || rd.start == r_now || diff_m1 < p_eff) begin
                    n_state = S_FINISH;
                end else if (over_one < p_eff) begin
                    n_n     = TIME_W'(1);
                    n_start = r_now - TIME_W'(1) - over_one;
                    n_state = S_DECAY;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_n     = div_quo;
                    // start + n*p, with n*p = diff_m1 - remainder
                    n_start = r_now - TIME_W'(1) - div_rem;
                    n_state = S_DECAY;
                end
            end
            S_DECAY: begin
                n_heat  = blend_val;
                n_count = '0;
                n_n     = r_n - TIME_W'(1);
                if (settled || r_n == TIME_W'(1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                wr.en        = r_inr;
                wr.set_valid = 1'b1;
                wr.data      = '{heat: r_heat, count: r_count, start: r_start};
                if (r_act == ACT_ADD) begin
                    if (r_start == '0) begin
                        wr.data = '{heat: '0, count: r_cnt, start: r_now};
                    end else begin
                        wr.data.count = r_count + r_cnt;
                    end
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_heat_out  = (r_count == '0) ? r_heat : blend_val;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_inr       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_inr       <= n_inr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_idx <= IDX_W'(i_entry_index);
            r_now <= i_time_now;
            r_cnt <= i_access_count;
        end
        r_heat     <= n_heat;
        r_count    <= n_count;
        r_start    <= n_start;
        r_n        <= n_n;
        r_heat_out <= n_heat_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_heat_out  = r_heat_out;

    // the divider only runs while a request is in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_busy)
        else $error("divider busy while idle");

    // the decay loop always has at least one period left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECAY) |-> (r_n != '0))
        else $error("decay loop entered with no period");

    // an accepted request is read from memory in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted request not read");

    // a new result only comes out of the write-back step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside write-back");

endmodule

`default_nettype wire
